// File: design/owo_pkg.sv
package owo_pkg;

    // stream payload layout
    localparam int WHEEL_W       = 32;
    localparam int HEADING_W     = 16;
    localparam int NUM_WHEELS    = 4;
    localparam int S_TDATA_W     = NUM_WHEELS * WHEEL_W + HEADING_W;
    localparam int WORLD_FIELD_W = 32;
    localparam int M_TDATA_W     = 2 * WORLD_FIELD_W + HEADING_W;
    localparam int M_TUSER_W     = 1;

    // configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_DELTA_SCALE     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_X       = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_Y       = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_HEADING = 8'd3;

    localparam logic [31:0] DELTA_SCALE_RESET = 32'd214748;

    // parameter defaults
    localparam int POSITION_WIDTH_DEF = 32;
    localparam int CORDIC_STEPS_DEF   = 16;

    // datapath widths
    localparam int MUL_A_W     = 34;   // body sum, widest signed operand
    localparam int MUL_B_W     = 33;   // unsigned scale with a sign bit
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int BODY_SUM_W  = MUL_A_W;
    localparam int BODY_W      = 33;
    localparam int CORDIC_W    = 32;
    localparam int ANGLE_W     = 33;
    localparam int ATAN_W      = 30;
    localparam int ATAN_IDX_W  = 5;
    localparam int WHEEL_SHIFT = 32;
    localparam int BODY_SHIFT  = 31;
    localparam int ROT_SHIFT   = 30;

    localparam logic signed [MUL_B_W-1:0] SQRT2_QUARTER_Q31 = 33'sd759250125;
    localparam logic [63:0] GAIN_LIMIT_Q30 = 64'd652032874;
    localparam logic [63:0] GAIN_TAIL_Q30  = 64'd434688583;

    // multiplier operand selections, also used as the product tag
    localparam int MUL_SEL_W = 4;
    localparam logic [MUL_SEL_W-1:0] MUL_NONE = 4'd0;
    localparam logic [MUL_SEL_W-1:0] MUL_W0   = 4'd1;
    localparam logic [MUL_SEL_W-1:0] MUL_W1   = 4'd2;
    localparam logic [MUL_SEL_W-1:0] MUL_W2   = 4'd3;
    localparam logic [MUL_SEL_W-1:0] MUL_W3   = 4'd4;
    localparam logic [MUL_SEL_W-1:0] MUL_SX   = 4'd5;
    localparam logic [MUL_SEL_W-1:0] MUL_SY   = 4'd6;
    localparam logic [MUL_SEL_W-1:0] MUL_BXC  = 4'd7;
    localparam logic [MUL_SEL_W-1:0] MUL_BYS  = 4'd8;
    localparam logic [MUL_SEL_W-1:0] MUL_BYC  = 4'd9;
    localparam logic [MUL_SEL_W-1:0] MUL_BXS  = 4'd10;

    typedef struct packed {
        logic                  load;
        logic [MUL_SEL_W-1:0]  mul_sel;
        logic                  cordic_en;
        logic [ATAN_IDX_W-1:0] cordic_idx;
        logic                  update;
    } owo_cmd_t;

    // arctangent of 2^-i, 32-bit binary angle
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] a;
        case (idx)
            5'd0:    a = 30'h20000000;
            5'd1:    a = 30'h12E4051E;
            5'd2:    a = 30'h09FB385B;
            5'd3:    a = 30'h051111D4;
            5'd4:    a = 30'h028B0D43;
            5'd5:    a = 30'h0145D7E1;
            5'd6:    a = 30'h00A2F61E;
            5'd7:    a = 30'h00517C55;
            5'd8:    a = 30'h0028BE53;
            5'd9:    a = 30'h00145F2F;
            5'd10:   a = 30'h000A2F98;
            5'd11:   a = 30'h000517CC;
            5'd12:   a = 30'h00028BE6;
            5'd13:   a = 30'h000145F3;
            5'd14:   a = 30'h0000A2F9;
            5'd15:   a = 30'h0000517C;
            5'd16:   a = 30'h000028BE;
            5'd17:   a = 30'h0000145F;
            5'd18:   a = 30'h00000A2F;
            5'd19:   a = 30'h00000517;
            5'd20:   a = 30'h0000028B;
            5'd21:   a = 30'h00000145;
            5'd22:   a = 30'h000000A2;
            5'd23:   a = 30'h00000051;
            default: a = '0;
        endcase
        return a;
    endfunction

    // start magnitude in q1.30, the inverse cordic gain for the given step count
    function automatic logic [CORDIC_W-1:0] cordic_gain(input int steps);
        logic [63:0] tail;
        tail = GAIN_TAIL_Q30 + (64'd1 << (2 * steps - 1));
        return CORDIC_W'(GAIN_LIMIT_Q30 + (tail >> (2 * steps)));
    endfunction

endpackage

// File: design/owo_ctrl.sv
module owo_ctrl #(
    parameter int CORDIC_STEPS = owo_pkg::CORDIC_STEPS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output owo_pkg::owo_cmd_t cmd
);
    import owo_pkg::*;

    localparam int CNT_W = $clog2(CORDIC_STEPS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WHEEL  = 3'd1;
    localparam logic [2:0] ST_WDRAIN = 3'd2;
    localparam logic [2:0] ST_BODY   = 3'd3;
    localparam logic [2:0] ST_CORDIC = 3'd4;
    localparam logic [2:0] ST_ROT    = 3'd5;
    localparam logic [2:0] ST_RDRAIN = 3'd6;
    localparam logic [2:0] ST_UPDATE = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_WHEEL;
                end
            end
            ST_WHEEL: begin
                cmd.mul_sel = MUL_W0 + MUL_SEL_W'(cnt_reg);
                if (cnt_reg == CNT_W'(NUM_WHEELS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_WDRAIN;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_WDRAIN: begin
                state_next = ST_BODY;
            end
            ST_BODY: begin
                // y product lands while cordic runs
                cmd.mul_sel = MUL_SX + MUL_SEL_W'(cnt_reg);
                if (cnt_reg == CNT_W'(1)) begin
                    cnt_next   = '0;
                    state_next = ST_CORDIC;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_CORDIC: begin
                cmd.cordic_en  = 1'b1;
                cmd.cordic_idx = ATAN_IDX_W'(cnt_reg);
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_ROT;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_ROT: begin
                cmd.mul_sel = MUL_BXC + MUL_SEL_W'(cnt_reg);
                if (cnt_reg == CNT_W'(3)) begin
                    cnt_next   = '0;
                    state_next = ST_RDRAIN;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_RDRAIN: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                // position and output move together once the output slot is free
                if (!out_valid_reg || m_tready) begin
                    cmd.update     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

// File: design/owo_datapath.sv
module owo_datapath #(
    parameter int POSITION_WIDTH = owo_pkg::POSITION_WIDTH_DEF,
    parameter int CORDIC_STEPS   = owo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  owo_pkg::owo_cmd_t               cmd,
    input  logic [owo_pkg::S_TDATA_W-1:0]   in_data,
    input  logic                            cfg_we,
    input  logic [owo_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [owo_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [owo_pkg::M_TDATA_W-1:0]   out_data,
    output logic                            out_clipped
);
    import owo_pkg::*;

    localparam int WORLD_W = PROD_W - ROT_SHIFT;
    localparam int SUM_W   = ((POSITION_WIDTH > WORLD_W) ? POSITION_WIDTH : WORLD_W) + 1;
    localparam int EXT_W   = (POSITION_WIDTH > WORLD_FIELD_W) ? POSITION_WIDTH : WORLD_FIELD_W;

    localparam logic signed [SUM_W-1:0] POS_MAX =
        {{(SUM_W - POSITION_WIDTH + 1){1'b0}}, {(POSITION_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] POS_MIN = ~POS_MAX;

    localparam logic signed [PROD_W-1:0] HALF_WHEEL = PROD_W'(1) << (WHEEL_SHIFT - 1);
    localparam logic signed [PROD_W-1:0] HALF_BODY  = PROD_W'(1) << (BODY_SHIFT - 1);
    localparam logic signed [PROD_W-1:0] HALF_ROT   = PROD_W'(1) << (ROT_SHIFT - 1);

    localparam logic signed [CORDIC_W-1:0]  GAIN         = cordic_gain(CORDIC_STEPS);
    localparam logic signed [ANGLE_W-1:0]   HALF_TURN    = 33'sh080000000;
    localparam logic signed [HEADING_W-1:0] QUARTER_TURN = 16'sd16384;

    function automatic logic signed [POSITION_WIDTH-1:0] sat_pos(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0] c;
        if (v > POS_MAX) begin
            c = POS_MAX;
        end else if (v < POS_MIN) begin
            c = POS_MIN;
        end else begin
            c = v;
        end
        return c[POSITION_WIDTH-1:0];
    endfunction

    // configuration and position state
    logic [31:0]                       delta_scale_reg, delta_scale_next;
    logic signed [POSITION_WIDTH-1:0]  pos_x_reg, pos_x_next;
    logic signed [POSITION_WIDTH-1:0]  pos_y_reg, pos_y_next;
    logic [HEADING_W-1:0]              held_hdg_reg, held_hdg_next;
    logic                              clipped_reg, clipped_next;
    logic [WHEEL_W-1:0]                prev_reg [NUM_WHEELS];

    // per-item working registers
    logic signed [WHEEL_W-1:0]    delta_reg [NUM_WHEELS];
    logic [HEADING_W-1:0]         hdg_in_reg;
    logic signed [BODY_SUM_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [BODY_W-1:0]     bx_reg, bx_next, by_reg, by_next;
    logic signed [CORDIC_W-1:0]   cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ANGLE_W-1:0]    cz_reg, cz_next;
    logic signed [PROD_W-1:0]     prod_reg, prod_next;
    logic [MUL_SEL_W-1:0]         tag_reg;
    logic signed [PROD_W-1:0]     wx_acc_reg, wx_acc_next, wy_acc_reg, wy_acc_next;

    logic signed [MUL_A_W-1:0]    mul_a;
    logic signed [MUL_B_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]     round_wheel, round_body, round_wx, round_wy;
    logic signed [WHEEL_W-1:0]    wheel_v;
    logic signed [BODY_SUM_W-1:0] wheel_v_ext;
    logic signed [BODY_W-1:0]     body_v;
    logic signed [WORLD_W-1:0]    world_dx, world_dy;
    logic signed [SUM_W-1:0]      sum_x, sum_y;
    logic signed [SUM_W-1:0]      cfg_pos;
    logic signed [HEADING_W-1:0]  in_heading;
    logic signed [ANGLE_W-1:0]    z_start;
    logic signed [ANGLE_W-1:0]    atan_step;
    logic signed [EXT_W-1:0]      pos_x_ext, pos_y_ext;

    assign in_heading = in_data[NUM_WHEELS*WHEEL_W +: HEADING_W];
    assign z_start    = {in_heading[HEADING_W-1], in_heading, 16'h0000};
    assign atan_step  = ANGLE_W'(atan_entry(cmd.cordic_idx));

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_W0: begin
                mul_a = MUL_A_W'(delta_reg[0]);
                mul_b = {1'b0, delta_scale_reg};
            end
            MUL_W1: begin
                mul_a = MUL_A_W'(delta_reg[1]);
                mul_b = {1'b0, delta_scale_reg};
            end
            MUL_W2: begin
                mul_a = MUL_A_W'(delta_reg[2]);
                mul_b = {1'b0, delta_scale_reg};
            end
            MUL_W3: begin
                mul_a = MUL_A_W'(delta_reg[3]);
                mul_b = {1'b0, delta_scale_reg};
            end
            MUL_SX: begin
                mul_a = sx_reg;
                mul_b = SQRT2_QUARTER_Q31;
            end
            MUL_SY: begin
                mul_a = sy_reg;
                mul_b = SQRT2_QUARTER_Q31;
            end
            MUL_BXC: begin
                mul_a = MUL_A_W'(bx_reg);
                mul_b = MUL_B_W'(cx_reg);
            end
            MUL_BYS: begin
                mul_a = MUL_A_W'(by_reg);
                mul_b = MUL_B_W'(cy_reg);
            end
            MUL_BYC: begin
                mul_a = MUL_A_W'(by_reg);
                mul_b = MUL_B_W'(cx_reg);
            end
            MUL_BXS: begin
                mul_a = MUL_A_W'(bx_reg);
                mul_b = MUL_B_W'(cy_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // rounding taps on the registered product and the rotation sums
    assign round_wheel = prod_reg + HALF_WHEEL;
    assign round_body  = prod_reg + HALF_BODY;
    assign wheel_v     = round_wheel[WHEEL_SHIFT +: WHEEL_W];
    assign wheel_v_ext = BODY_SUM_W'(wheel_v);
    assign body_v      = round_body[BODY_SHIFT +: BODY_W];
    assign round_wx    = wx_acc_reg + HALF_ROT;
    assign round_wy    = wy_acc_reg + HALF_ROT;
    assign world_dx    = round_wx[ROT_SHIFT +: WORLD_W];
    assign world_dy    = round_wy[ROT_SHIFT +: WORLD_W];
    assign sum_x       = SUM_W'(pos_x_reg) + SUM_W'(world_dx);
    assign sum_y       = SUM_W'(pos_y_reg) + SUM_W'(world_dy);
    assign cfg_pos     = SUM_W'($signed(cfg_data));

    // product consumption, keyed by the tag of the operation that made it
    always_comb begin
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        bx_next     = bx_reg;
        by_next     = by_reg;
        wx_acc_next = wx_acc_reg;
        wy_acc_next = wy_acc_reg;
        if (cmd.load) begin
            sx_next = '0;
            sy_next = '0;
        end
        case (tag_reg)
            MUL_W0: begin
                sx_next = sx_reg - wheel_v_ext;
                sy_next = sy_reg + wheel_v_ext;
            end
            MUL_W1: begin
                sx_next = sx_reg - wheel_v_ext;
                sy_next = sy_reg - wheel_v_ext;
            end
            MUL_W2: begin
                sx_next = sx_reg + wheel_v_ext;
                sy_next = sy_reg - wheel_v_ext;
            end
            MUL_W3: begin
                sx_next = sx_reg + wheel_v_ext;
                sy_next = sy_reg + wheel_v_ext;
            end
            MUL_SX:  bx_next = body_v;
            MUL_SY:  by_next = body_v;
            MUL_BXC: wx_acc_next = prod_reg;
            MUL_BYS: wx_acc_next = wx_acc_reg - prod_reg;
            MUL_BYC: wy_acc_next = prod_reg;
            MUL_BXS: wy_acc_next = wy_acc_reg + prod_reg;
            default: ;
        endcase
    end

    // cordic start vector on load, then rotation one step a cycle
    always_comb begin
        cx_next = cx_reg;
        cy_next = cy_reg;
        cz_next = cz_reg;
        if (cmd.load) begin
            cy_next = '0;
            if (in_heading > QUARTER_TURN) begin
                cx_next = -GAIN;
                cz_next = z_start - HALF_TURN;
            end else if (in_heading < -QUARTER_TURN) begin
                cx_next = -GAIN;
                cz_next = z_start + HALF_TURN;
            end else begin
                cx_next = GAIN;
                cz_next = z_start;
            end
        end else if (cmd.cordic_en) begin
            if (!cz_reg[ANGLE_W-1]) begin
                cx_next = cx_reg - (cy_reg >>> cmd.cordic_idx);
                cy_next = cy_reg + (cx_reg >>> cmd.cordic_idx);
                cz_next = cz_reg - atan_step;
            end else begin
                cx_next = cx_reg + (cy_reg >>> cmd.cordic_idx);
                cy_next = cy_reg - (cx_reg >>> cmd.cordic_idx);
                cz_next = cz_reg + atan_step;
            end
        end
    end

    // position, heading and configuration
    always_comb begin
        delta_scale_next = delta_scale_reg;
        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        held_hdg_next    = held_hdg_reg;
        clipped_next     = clipped_reg;
        if (cmd.update) begin
            pos_x_next    = sat_pos(sum_x);
            pos_y_next    = sat_pos(sum_y);
            held_hdg_next = hdg_in_reg;
            clipped_next  = (sum_x > POS_MAX) || (sum_x < POS_MIN) ||
                            (sum_y > POS_MAX) || (sum_y < POS_MIN);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DELTA_SCALE:     delta_scale_next = cfg_data;
                REG_INITIAL_X:       pos_x_next = sat_pos(cfg_pos);
                REG_INITIAL_Y:       pos_y_next = sat_pos(cfg_pos);
                REG_INITIAL_HEADING: held_hdg_next = cfg_data[HEADING_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delta_scale_reg <= DELTA_SCALE_RESET;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            held_hdg_reg    <= '0;
            clipped_reg     <= 1'b0;
            tag_reg         <= MUL_NONE;
            for (int k = 0; k < NUM_WHEELS; k++) begin
                prev_reg[k] <= '0;
            end
        end else begin
            delta_scale_reg <= delta_scale_next;
            pos_x_reg       <= pos_x_next;
            pos_y_reg       <= pos_y_next;
            held_hdg_reg    <= held_hdg_next;
            clipped_reg     <= clipped_next;
            tag_reg         <= cmd.mul_sel;
            if (cmd.load) begin
                for (int k = 0; k < NUM_WHEELS; k++) begin
                    prev_reg[k] <= in_data[k*WHEEL_W +: WHEEL_W];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int k = 0; k < NUM_WHEELS; k++) begin
                delta_reg[k] <= in_data[k*WHEEL_W +: WHEEL_W] - prev_reg[k];
            end
            hdg_in_reg <= in_data[NUM_WHEELS*WHEEL_W +: HEADING_W];
        end
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cz_reg     <= cz_next;
        prod_reg   <= prod_next;
        wx_acc_reg <= wx_acc_next;
        wy_acc_reg <= wy_acc_next;
    end

    assign pos_x_ext   = EXT_W'(pos_x_reg);
    assign pos_y_ext   = EXT_W'(pos_y_reg);
    assign out_data    = {held_hdg_reg, pos_y_ext[WORLD_FIELD_W-1:0],
                          pos_x_ext[WORLD_FIELD_W-1:0]};
    assign out_clipped = clipped_reg;

endmodule

// File: design/omni_wheel_odometry_top.sv
// four-wheel omni drive odometry with the wheels at 45 degrees. each transfer on the
// input stream carries four wheel encoder angles (q16.16 radians) and an imu heading
// (binary angle, 32768 = pi); the block differences each angle against the previous
// transfer, scales it by delta_scale, forms body x/y motion with the sqrt(2)/4 omni
// kinematics, rotates it into world axes with a cordic sine/cosine of the heading and
// adds it to the stored position, saturating to POSITION_WIDTH and raising clipped.
// exactly one result transfer follows each input transfer. four wheel products,
// two body products and four rotation products go one a cycle through a single
// shared 34 x 33 multiplier, and the cordic does one micro-rotation a cycle; the
// next item is taken the cycle after the result is loaded, so the block does not
// take a new item before it is through with the last one.
// a finished result sits in the output register while the next item is already
// being worked on; that item only stalls at its final update if the earlier result
// has still not been taken.
// configuration writes (delta_scale, initial x, initial y, initial heading) are
// always ready and should be made while the block is idle; writing an initial
// position or heading loads it straight into the live state.
module omni_wheel_odometry_top #(
    parameter int POSITION_WIDTH = owo_pkg::POSITION_WIDTH_DEF,
    parameter int CORDIC_STEPS   = owo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // wheel_angle_one, wheel_angle_two, wheel_angle_three, wheel_angle_four, imu_heading
    input  logic [owo_pkg::S_TDATA_W-1:0]   s_tdata,

    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // world_x, world_y, heading_out
    output logic [owo_pkg::M_TDATA_W-1:0]   m_tdata,
    // clipped
    output logic [owo_pkg::M_TUSER_W-1:0]   m_tuser,

    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [owo_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [owo_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import owo_pkg::*;

    owo_cmd_t cmd;
    logic     clipped;

    // sequencer: issues loads, multiplier selections, cordic steps and the final update
    owo_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // datapath: wheel history, shared multiplier, cordic, position and config registers
    owo_datapath #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .CORDIC_STEPS   (CORDIC_STEPS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_data     (s_tdata),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_data    (m_tdata),
        .out_clipped (clipped)
    );

    // a write transfer always completes in its cycle
    assign cfg_ready = 1'b1;
    assign m_tuser   = M_TUSER_W'(clipped);

endmodule

// File: dv/tb_omni_wheel_odometry_top.sv
`timescale 1ns / 1ps

module tb_omni_wheel_odometry_top;
    import owo_pkg::*;

    // block parameters, kept at the defaults
    localparam int POSITION_BITS  = 32;
    localparam int ROTATION_STEPS = 16;

    // position limits of the signed position register
    localparam longint POS_MAX = (longint'(1) << (POSITION_BITS - 1)) - 1;
    localparam longint POS_MIN = -POS_MAX - 1;

    // sqrt(2)/4 in q1.31, half a turn as a 32-bit binary angle
    localparam longint BODY_GAIN_Q31 = 64'd759250125;
    localparam longint HALF_TURN     = 64'h8000_0000;

    // cordic start magnitude: inverse gain in q1.30 for the step count in use
    localparam longint CORDIC_GAIN_Q30 = 64'd652032874 +
        ((64'd434688583 + (longint'(1) << (2 * ROTATION_STEPS - 1))) >>> (2 * ROTATION_STEPS));

    localparam logic [31:0] SCALE_AT_RESET = 32'd214748;

    // register indexes beyond the map, writes to them must leave everything alone
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST  = 8'hFF;

    // receiver hold-off for the back-pressure test, and the quiet time at the end
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 40;

    // one input transfer: wheel one in the lowest bits, heading on top
    typedef struct packed {
        logic signed [15:0] imu_heading;
        logic [3:0][31:0]   wheel_angle;
    } odo_item_t;

    // one result transfer, clipped taken from tuser above the tdata fields
    typedef struct packed {
        logic        clipped;
        logic [15:0] heading;
        logic [31:0] world_y;
        logic [31:0] world_x;
    } pose_t;

    typedef struct {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  value;
    } reg_write_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // own copy of the odometry state and of the registers
    logic [31:0] travel_scale;
    logic [31:0] last_angle [4];
    longint      pos_x;
    longint      pos_y;
    logic [15:0] held_heading;

    // arctangent of 2^-i as a 32-bit binary angle
    longint atan_bam [16] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C
    };

    // angles and heading the stimulus last commanded, so motion stays continuous
    logic [31:0] drive_angle [4];
    logic [15:0] drive_heading;

    pose_t      expected_poses [$];
    reg_write_t write_backlog [$];

    // handshake pacing controls shared by the test tasks and the receiver
    bit feed_gaps     = 1'b0;
    bit sink_stalls   = 1'b0;
    bit hold_request  = 1'b0;

    int faults        = 0;
    int items_sent    = 0;
    int poses_checked = 0;
    int clipped_seen  = 0;

    pose_t got_pose;
    pose_t want_pose;

    omni_wheel_odometry_top #(
        .POSITION_WIDTH (POSITION_BITS),
        .CORDIC_STEPS   (ROTATION_STEPS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------------------
    // odometry prediction
    // ---------------------------------------------------------------------------------

    // floor(v / 2^n + 1/2), wrapping like any 64-bit two's complement sum
    function automatic longint round_half_up(input longint v, input int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clamp_position(input longint v, inout bit hit);
        if (v > POS_MAX) begin
            hit = 1'b1;
            return POS_MAX;
        end
        if (v < POS_MIN) begin
            hit = 1'b1;
            return POS_MIN;
        end
        return v;
    endfunction

    // cosine and sine of the heading in q1.30; beyond a quarter turn the angle is
    // folded by half a turn and the start vector negated
    function automatic void heading_cos_sin(input logic signed [15:0] hd,
                                            output longint cos_v, output longint sin_v);
        longint ax, ay, az, dx, dy;
        ax = CORDIC_GAIN_Q30;
        ay = 0;
        az = longint'(hd) * 65536;
        if (hd > 16384) begin
            az -= HALF_TURN;
            ax = -CORDIC_GAIN_Q30;
        end else if (hd < -16384) begin
            az += HALF_TURN;
            ax = -CORDIC_GAIN_Q30;
        end
        for (int i = 0; i < ROTATION_STEPS; i++) begin
            dx = ay >>> i;
            dy = ax >>> i;
            if (az >= 0) begin
                ax -= dx;
                ay += dy;
                az -= atan_bam[i];
            end else begin
                ax += dx;
                ay -= dy;
                az += atan_bam[i];
            end
        end
        cos_v = ax;
        sin_v = ay;
    endfunction

    // moves the own state by one item and returns the pose the block should report
    function automatic pose_t advance_pose(input odo_item_t it);
        longint      travel [4];
        longint      sum_x, sum_y, body_x, body_y, cos_v, sin_v, step_x, step_y;
        logic [31:0] turn;
        bit          hit;
        pose_t       p;
        hit = 1'b0;
        for (int k = 0; k < 4; k++) begin
            // wheel turn taken modulo 2^32, then scaled to a travel in q16.16
            turn = it.wheel_angle[k] - last_angle[k];
            travel[k] = round_half_up(longint'($signed(turn)) * longint'(travel_scale), 32);
            last_angle[k] = it.wheel_angle[k];
        end
        // 45 degree omni kinematics
        sum_x = -travel[0] - travel[1] + travel[2] + travel[3];
        sum_y =  travel[0] - travel[1] - travel[2] + travel[3];
        body_x = round_half_up(sum_x * BODY_GAIN_Q31, 31);
        body_y = round_half_up(sum_y * BODY_GAIN_Q31, 31);
        // body to world axes
        heading_cos_sin(it.imu_heading, cos_v, sin_v);
        step_x = round_half_up(body_x * cos_v - body_y * sin_v, 30);
        step_y = round_half_up(body_y * cos_v + body_x * sin_v, 30);
        pos_x = clamp_position(pos_x + step_x, hit);
        pos_y = clamp_position(pos_y + step_y, hit);
        held_heading = it.imu_heading;
        p.clipped = hit;
        p.heading = held_heading;
        p.world_y = 32'(pos_y);
        p.world_x = 32'(pos_x);
        return p;
    endfunction

    function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] value);
        bit unused_hit;
        unused_hit = 1'b0;
        case (idx)
            REG_DELTA_SCALE: begin
                travel_scale = value;
            end
            REG_INITIAL_X: begin
                pos_x = clamp_position(longint'($signed(value)), unused_hit);
            end
            REG_INITIAL_Y: begin
                pos_y = clamp_position(longint'($signed(value)), unused_hit);
            end
            REG_INITIAL_HEADING: begin
                held_heading = value[15:0];
            end
            default: begin
                // unmapped index, nothing changes
            end
        endcase
    endfunction

    function automatic void reset_pose_model();
        travel_scale = SCALE_AT_RESET;
        pos_x        = 0;
        pos_y        = 0;
        held_heading = '0;
        for (int k = 0; k < 4; k++) begin
            last_angle[k]  = '0;
            drive_angle[k] = '0;
        end
        drive_heading = '0;
    endfunction

    // ---------------------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------------------

    function automatic odo_item_t make_item(input logic [31:0] w1, input logic [31:0] w2,
                                            input logic [31:0] w3, input logic [31:0] w4,
                                            input logic [15:0] hd);
        odo_item_t it;
        drive_angle[0] = w1;
        drive_angle[1] = w2;
        drive_angle[2] = w3;
        drive_angle[3] = w4;
        drive_heading  = hd;
        it.imu_heading = hd;
        for (int k = 0; k < 4; k++) it.wheel_angle[k] = drive_angle[k];
        return it;
    endfunction

    // mostly plausible robot motion (small wheel turns, drifting heading), some
    // larger jumps that wrap the encoders, and some plain noise
    function automatic odo_item_t pick_item();
        odo_item_t   it;
        int unsigned roll;
        int unsigned span;
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            for (int k = 0; k < 4; k++) drive_angle[k] = $urandom;
            drive_heading = 16'($urandom);
        end else begin
            span = (roll < 75) ? 32'h0001_0000 : ((roll < 95) ? 32'h0100_0000 : 32'h3FFF_FFFF);
            for (int k = 0; k < 4; k++) begin
                drive_angle[k] = drive_angle[k] + 32'(int'($urandom_range(0, 2 * span)) - int'(span));
            end
            drive_heading = drive_heading + 16'($urandom_range(0, 1024)) - 16'd512;
            if ($urandom_range(0, 19) == 0) drive_heading = 16'($urandom);
        end
        it.imu_heading = drive_heading;
        for (int k = 0; k < 4; k++) it.wheel_angle[k] = drive_angle[k];
        return it;
    endfunction

    // offers one item and waits for its transfer; valid stays high so a following
    // item goes out back to back
    task automatic send_item(input odo_item_t it);
        if (feed_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_poses.push_back(advance_pose(it));
        items_sent++;
    endtask

    // sender goes quiet until every pose it is owed has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_poses.size() != 0) @(posedge aclk);
    endtask

    function automatic void queue_write(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] value);
        reg_write_t w;
        w.index = idx;
        w.value = value;
        write_backlog.push_back(w);
    endfunction

    // register writes back to back on the config channel, only while the block is idle
    task automatic apply_writes();
        reg_write_t w;
        while (write_backlog.size() != 0) begin
            w = write_backlog.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.index;
            cfg_data  <= w.value;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            apply_register(w.index, w.value);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic set_registers(input logic [31:0] scale, input logic [31:0] start_x,
                                 input logic [31:0] start_y, input logic [15:0] start_hd);
        wait_drained();
        queue_write(REG_DELTA_SCALE, scale);
        queue_write(REG_INITIAL_X, start_x);
        queue_write(REG_INITIAL_Y, start_y);
        // upper data bits are don't-care for the heading register, so keep them busy
        queue_write(REG_INITIAL_HEADING, {16'($urandom), start_hd});
        apply_writes();
    endtask

    task automatic run_phase(input int items, input bit gaps, input bit stalls);
        feed_gaps   = gaps;
        sink_stalls = stalls;
        repeat (items) send_item(pick_item());
        wait_drained();
    endtask

    // ---------------------------------------------------------------------------------
    // receiver: random stall bursts, or one long hold-off when asked for
    // ---------------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------------------
    // result checking, one pose per output transfer against the oldest prediction
    // ---------------------------------------------------------------------------------
    function automatic void note_mismatch(input string field, input logic [31:0] want_v,
                                          input logic [31:0] got_v);
        faults++;
        $display("%0t ns: %s mismatch, expected %h actual %h", $time, field, want_v, got_v);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_pose = {m_tuser[0], m_tdata};
            if (expected_poses.size() == 0) begin
                faults++;
                $display("%0t ns: pose transfer with nothing pending, actual %h",
                         $time, got_pose);
            end else begin
                want_pose = expected_poses.pop_front();
                poses_checked++;
                if (want_pose.clipped) clipped_seen++;
                if (got_pose.world_x !== want_pose.world_x) begin
                    note_mismatch("world_x", want_pose.world_x, got_pose.world_x);
                end
                if (got_pose.world_y !== want_pose.world_y) begin
                    note_mismatch("world_y", want_pose.world_y, got_pose.world_y);
                end
                if (got_pose.heading !== want_pose.heading) begin
                    note_mismatch("heading_out", 32'(want_pose.heading), 32'(got_pose.heading));
                end
                if (got_pose.clipped !== want_pose.clipped) begin
                    note_mismatch("clipped", 32'(want_pose.clipped), 32'(got_pose.clipped));
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------------------

    // reset registers, encoder extremes and wrap-around of the angle difference
    task automatic test_reset_extremes();
        send_item(make_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                            16'h0000));
        send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                            16'h7FFF));
        send_item(make_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                            16'h8000));
        send_item(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            16'hFFFF));
        send_item(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            16'h0001));
    endtask

    // headings on and just past the quarter turns, where the cordic input is folded
    task automatic test_heading_fold();
        logic [15:0] corner [8];
        corner = '{16'h4000, 16'h4001, 16'hC000, 16'hBFFF, 16'h7FFF, 16'h8000,
                   16'h0000, 16'h2000};
        wait_drained();
        queue_write(REG_DELTA_SCALE, 32'h0100_0000);
        apply_writes();
        for (int i = 0; i < 8; i++) begin
            send_item(make_item(drive_angle[0] + 32'h0400_0000, drive_angle[1] - 32'h0100_0000,
                                drive_angle[2] + 32'h0200_0000, drive_angle[3] + 32'h0080_0000,
                                corner[i]));
        end
    endtask

    // start next to the position limits with full scale so both axes saturate,
    // then come back off them
    task automatic test_saturation();
        set_registers(32'hFFFF_FFFF, 32'h7FFF_0000, 32'h8001_0000, 16'h0000);
        repeat (3) begin
            send_item(make_item(drive_angle[0], drive_angle[1], drive_angle[2] + 32'h1000_0000,
                                drive_angle[3], 16'h0000));
        end
        repeat (3) begin
            send_item(make_item(drive_angle[0], drive_angle[1], drive_angle[2] - 32'h1000_0000,
                                drive_angle[3], 16'h0000));
        end
    endtask

    // writes to unmapped indexes must not disturb the registers or the state
    task automatic test_spare_index();
        wait_drained();
        queue_write(REG_SPARE_FIRST, $urandom);
        queue_write(REG_SPARE_LAST, $urandom);
        apply_writes();
        send_item(pick_item());
    endtask

    // random motion under a run of register settings, extremes among them
    task automatic test_random_settings();
        set_registers(SCALE_AT_RESET, 32'h0000_0000, 32'h0000_0000, 16'h0000);
        run_phase(450, 1'b1, 1'b1);
        set_registers(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF);
        run_phase(200, 1'b1, 1'b0);
        set_registers(32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000);
        run_phase(100, 1'b0, 1'b1);
        set_registers($urandom, $urandom, $urandom, 16'($urandom));
        run_phase(400, 1'b0, 1'b0);
        set_registers(32'h0010_0000 + $urandom_range(0, 32'h000F_FFFF), $urandom,
                      $urandom, 16'($urandom));
        run_phase(400, 1'b1, 1'b1);
    endtask

    // long receiver hold-off while items keep coming, so the block fills and
    // pushes back on its input; then bursts separated by a full drain
    task automatic test_output_hold();
        feed_gaps   = 1'b0;
        sink_stalls = 1'b0;
        wait_drained();
        hold_request = 1'b1;
        repeat (12) send_item(pick_item());
        wait_drained();
        feed_gaps   = 1'b1;
        sink_stalls = 1'b1;
        repeat (15) send_item(pick_item());
        wait_drained();
        repeat (15) send_item(pick_item());
        wait_drained();
    endtask

    // closing stretch at full rate, no idling on either side
    task automatic test_full_rate_tail();
        set_registers(SCALE_AT_RESET, $urandom, $urandom, 16'($urandom));
        run_phase(300, 1'b0, 1'b0);
    endtask

    // ---------------------------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------------------------
    initial begin
        reset_pose_model();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_extremes();
        test_heading_fold();
        test_saturation();
        test_spare_index();
        test_random_settings();
        test_output_hold();
        test_full_rate_tail();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d odometry updates, %0d poses checked, %0d clipped at a limit",
                 items_sent, poses_checked, clipped_seen);
        $display("settings: reset, zero and full scale, extreme start poses, folded headings");
        if (faults == 0 && expected_poses.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #4_000_000;
        $display("%0t ns: run did not finish, %0d poses still pending", $time,
                 expected_poses.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
design/owo_pkg.sv
design/owo_ctrl.sv
design/owo_datapath.sv
design/omni_wheel_odometry_top.sv
dv/tb_omni_wheel_odometry_top.sv
